FILE: rtl/mqts_pkg.sv
package mqts_pkg;

  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_DEQ = 2'd1;
  localparam logic [1:0] MODE_QRY = 2'd2;

  // maximum reported while nothing is held
  localparam logic signed [31:0] EMPTY_MAX = -32'sd2000000000;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } mqts_in_t;

  typedef struct packed {
    logic signed [31:0] head_value;
    logic signed [31:0] max_value;
    logic               is_empty;
    logic               refused;
  } mqts_out_t;

  // outbound stack entry: running maximum above, value below
  typedef struct packed {
    logic signed [31:0] max;
    logic signed [31:0] value;
  } mqts_pair_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_XFER_RD,
    ST_XFER_WR,
    ST_POP,
    ST_LOAD,
    ST_DONE
  } mqts_state_e;

  typedef struct packed {
    logic capture;
    logic enq;
    logic refuse;
    logic xfer_rd;
    logic xfer_wr;
    logic pop;
    logic load_top;
    logic finish;
  } mqts_cmd_t;

  typedef struct packed {
    logic is_enq;
    logic is_deq;
    logic full;
    logic empty;
    logic in_empty;
    logic out_empty;
    logic out_multi;
    logic out_free;
  } mqts_sts_t;

  function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: rtl/mqts_ctrl.sv
module mqts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mqts_pkg::mqts_sts_t sts_i,
  output mqts_pkg::mqts_cmd_t cmd_o
);
  import mqts_pkg::*;

  mqts_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.is_deq && !sts_i.empty) begin
          state_d = sts_i.out_empty ? ST_XFER_RD : ST_POP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_XFER_RD: state_d = ST_XFER_WR;
      ST_XFER_WR: state_d = sts_i.in_empty ? ST_POP : ST_XFER_RD;
      ST_POP:     state_d = sts_i.out_multi ? ST_LOAD : ST_DONE;
      ST_LOAD:    state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.capture  = in_valid_i;
      end
      ST_EXEC: begin
        if (sts_i.is_enq) begin
          cmd_o.enq    = !sts_i.full;
          cmd_o.refuse = sts_i.full;
        end else if (sts_i.is_deq) begin
          cmd_o.refuse = sts_i.empty;
        end
      end
      ST_XFER_RD: cmd_o.xfer_rd  = 1'b1;
      ST_XFER_WR: cmd_o.xfer_wr  = 1'b1;
      ST_POP:     cmd_o.pop      = 1'b1;
      ST_LOAD:    cmd_o.load_top = 1'b1;
      ST_DONE:    cmd_o.finish   = sts_i.out_free;
      default:    cmd_o          = '0;
    endcase
  end

endmodule

FILE: rtl/mqts_dp.sv
module mqts_dp #(
  parameter int DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mqts_pkg::mqts_in_t  in_data_i,
  input  mqts_pkg::mqts_cmd_t cmd_i,
  output mqts_pkg::mqts_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mqts_pkg::mqts_out_t out_data_o
);
  import mqts_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DEPTH_C = (CW + 1)'(DEPTH);

  logic [31:0] in_mem  [DEPTH];
  logic [63:0] out_mem [DEPTH];

  mqts_in_t           item_q;
  logic [CW-1:0]      in_cnt_q, in_cnt_d;
  logic [CW-1:0]      out_cnt_q, out_cnt_d;
  logic signed [31:0] in_max_q, in_max_d;
  mqts_pair_t         top_q, top_d;
  logic signed [31:0] head_q, head_d;
  logic               refused_q, refused_d;
  logic [31:0]        in_rdata_q;
  logic [63:0]        out_rdata_q;
  logic               out_valid_q, out_valid_d;
  mqts_out_t          out_q;

  logic [CW-1:0]      in_dec, out_dec, out_dec2;
  logic [CW:0]        total;
  logic               in_empty, out_empty;
  mqts_pair_t         xfer_pair;
  logic signed [31:0] qmax;

  assign in_dec   = in_cnt_q - 1'b1;
  assign out_dec  = out_cnt_q - 1'b1;
  assign out_dec2 = out_cnt_q - CW'(2);
  assign total    = {1'b0, in_cnt_q} + {1'b0, out_cnt_q};
  assign in_empty  = (in_cnt_q == '0);
  assign out_empty = (out_cnt_q == '0);

  assign sts_o.is_enq    = (item_q.mode == MODE_ENQ);
  assign sts_o.is_deq    = (item_q.mode == MODE_DEQ);
  assign sts_o.full      = (total >= DEPTH_C);
  assign sts_o.empty     = in_empty && out_empty;
  assign sts_o.in_empty  = in_empty;
  assign sts_o.out_empty = out_empty;
  assign sts_o.out_multi = (out_cnt_q >= CW'(2));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // entry moved across carries the maximum of itself and everything beneath
  always_comb begin
    xfer_pair.value = in_rdata_q;
    xfer_pair.max   = out_empty ? $signed(in_rdata_q) : smax(in_rdata_q, top_q.max);
  end

  always_comb begin
    if (!in_empty && !out_empty) begin
      qmax = smax(in_max_q, top_q.max);
    end else if (!in_empty) begin
      qmax = in_max_q;
    end else if (!out_empty) begin
      qmax = top_q.max;
    end else begin
      qmax = EMPTY_MAX;
    end
  end

  always_comb begin
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    in_max_d  = in_max_q;
    top_d     = top_q;
    head_d    = head_q;
    refused_d = refused_q;
    if (cmd_i.capture) begin
      head_d    = '0;
      refused_d = 1'b0;
    end
    if (cmd_i.refuse) refused_d = 1'b1;
    if (cmd_i.enq) begin
      in_cnt_d = in_cnt_q + 1'b1;
      in_max_d = in_empty ? item_q.value : smax(in_max_q, item_q.value);
    end
    if (cmd_i.xfer_rd) in_cnt_d = in_dec;
    if (cmd_i.xfer_wr) begin
      top_d     = xfer_pair;
      out_cnt_d = out_cnt_q + 1'b1;
    end
    if (cmd_i.pop) begin
      head_d    = top_q.value;
      out_cnt_d = out_dec;
    end
    if (cmd_i.load_top) top_d = mqts_pair_t'(out_rdata_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      in_max_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_cnt_q    <= in_cnt_d;
      out_cnt_q   <= out_cnt_d;
      in_max_q    <= in_max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
    top_q     <= top_d;
    head_q    <= head_d;
    refused_q <= refused_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq) in_mem[in_cnt_q[AW-1:0]] <= item_q.value;
    if (cmd_i.xfer_rd) in_rdata_q <= in_mem[in_dec[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.xfer_wr) out_mem[out_cnt_q[AW-1:0]] <= xfer_pair;
    // fetch the entry that becomes the new top once this one is popped
    if (cmd_i.pop) out_rdata_q <= out_mem[out_dec2[AW-1:0]];
  end

  assign out_valid_d = cmd_i.finish || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.head_value <= head_q;
      out_q.max_value  <= qmax;
      out_q.is_empty   <= in_empty && out_empty;
      out_q.refused    <= refused_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/max_queue_two_stack_top.sv
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  in_data_i   (mode, value)
// out      output     out_valid_o/out_stall_i out_data_o (head_value, max_value,
//                                                         is_empty, refused)
// enqueue, query and a refused dequeue pass through the idle, execute and done states;
// a dequeue adds a pop state, and a load state when a new top is fetched
// a dequeue that finds the outbound stack empty first moves every inbound entry across:
// each move is a registered read of the inbound memory then an outbound write
// one item is in work at a time; the next is taken once the result is in the
// output register, which holds it under stall while the next item runs
// reset clears the state, counts, inbound maximum and output valid only; the stack memories are not swept
module max_queue_two_stack_top #(
  parameter int DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mqts_pkg::mqts_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mqts_pkg::mqts_out_t out_data_o
);
  import mqts_pkg::*;

  mqts_cmd_t cmd;
  mqts_sts_t sts;

  mqts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mqts_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_enq_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.enq |-> !sts.full)
    else $error("enqueue issued on a full queue");

  a_xfer_has_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.xfer_rd |-> !sts.in_empty)
    else $error("transfer read with inbound stack empty");

  a_finish_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_o || !out_stall_i))
    else $error("result overwrites a waiting transaction");

  a_one_in_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transaction taken while one is in work");
`endif

endmodule
